// ===== rtl/acef_pkg.sv =====
// ============================================================================
// acef_pkg
// Shared types, character codes and the color lookup of the ANSI color
// escape filter.
// ============================================================================
package acef_pkg;

    localparam logic [7:0] CHAR_ESC      = 8'h1B;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_FINAL_M  = 8'h6D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;

    localparam logic [7:0] CODE_RESET    = 8'd0;
    localparam logic [7:0] CODE_FG_FIRST = 8'd30;
    localparam logic [7:0] CODE_FG_LAST  = 8'd37;
    localparam logic [7:0] CODE_BG_FIRST = 8'd40;
    localparam logic [7:0] CODE_BG_LAST  = 8'd47;
    localparam logic [7:0] CODE_MAX      = 8'd255;

    localparam logic [3:0] DEFAULT_FG    = 4'd7;
    localparam logic [3:0] DEFAULT_BG    = 4'd0;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_CSI  = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] code;
        logic [3:0] fg;
        logic [3:0] bg;
    } t_state;

    localparam t_state STATE_RESET = '{
        mode: MODE_TEXT,
        code: 8'd0,
        fg:   DEFAULT_FG,
        bg:   DEFAULT_BG
    };

    function automatic logic [3:0] ansi_to_vga(input logic [2:0] color);
        logic [3:0] vga;
        case (color)
            3'd0: vga = 4'd0;
            3'd1: vga = 4'd4;
            3'd2: vga = 4'd2;
            3'd3: vga = 4'd6;
            3'd4: vga = 4'd1;
            3'd5: vga = 4'd5;
            3'd6: vga = 4'd3;
            default: vga = 4'd7;
        endcase
        return vga;
    endfunction

endpackage

// ===== rtl/acef_parser.sv =====
// ============================================================================
// acef_parser
// Next-state logic of the escape parser: takes the current parser state and
// one character and gives the following state and whether the character is
// shown.
// ============================================================================
module acef_parser (
    input  acef_pkg::t_state i_state,
    input  logic [7:0]       i_char,
    output acef_pkg::t_state o_state,
    output logic             o_emit
);

    logic [11:0] accum_next;
    logic [7:0]  fg_offset;
    logic [7:0]  bg_offset;
    logic        is_digit;

    assign is_digit   = (i_char >= acef_pkg::CHAR_ZERO) && (i_char <= acef_pkg::CHAR_NINE);
    assign accum_next = ({4'd0, i_state.code} << 3) + ({4'd0, i_state.code} << 1)
                      + {8'd0, i_char[3:0]};
    assign fg_offset  = i_state.code - acef_pkg::CODE_FG_FIRST;
    assign bg_offset  = i_state.code - acef_pkg::CODE_BG_FIRST;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        case (i_state.mode)
            acef_pkg::MODE_ESC: begin
                if (i_char == acef_pkg::CHAR_LBRACKET) begin
                    o_state.mode = acef_pkg::MODE_CSI;
                    o_state.code = 8'd0;
                end else begin
                    o_state.mode = acef_pkg::MODE_TEXT;
                end
            end
            acef_pkg::MODE_CSI: begin
                if (is_digit) begin
                    if (accum_next > {4'd0, acef_pkg::CODE_MAX}) begin
                        o_state.code = acef_pkg::CODE_MAX;
                    end else begin
                        o_state.code = accum_next[7:0];
                    end
                end else begin
                    if (i_char == acef_pkg::CHAR_FINAL_M) begin
                        if (i_state.code == acef_pkg::CODE_RESET) begin
                            o_state.fg = acef_pkg::DEFAULT_FG;
                            o_state.bg = acef_pkg::DEFAULT_BG;
                        end else if (i_state.code >= acef_pkg::CODE_FG_FIRST &&
                                     i_state.code <= acef_pkg::CODE_FG_LAST) begin
                            o_state.fg = acef_pkg::ansi_to_vga(fg_offset[2:0]);
                        end else if (i_state.code >= acef_pkg::CODE_BG_FIRST &&
                                     i_state.code <= acef_pkg::CODE_BG_LAST) begin
                            o_state.bg = acef_pkg::ansi_to_vga(bg_offset[2:0]);
                        end
                    end
                    o_state.code = 8'd0;
                    o_state.mode = acef_pkg::MODE_TEXT;
                end
            end
            default: begin
                if (i_char == acef_pkg::CHAR_ESC) begin
                    o_state.mode = acef_pkg::MODE_ESC;
                end else begin
                    o_state.mode = acef_pkg::MODE_TEXT;
                    o_emit       = 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== rtl/ansi_color_escape_filter_unit.sv =====
// ============================================================================
// ansi_color_escape_filter_unit
// Strips ANSI color escape sequences from a console byte stream and tags each
// shown character with the current VGA foreground and background colors.
// ============================================================================
// The slave channel takes one character byte per transaction. Escape
// sequences (ESC, then '[' with a decimal code and 'm') are removed and
// change the current colors; every other byte leaves on the master channel
// together with its colors. Bytes that belong to an escape give no result.
// A byte is registered on acceptance and, once the output register is free,
// processed into the output register. The parser state is updated
// combinationally, so one byte can be accepted every cycle while the
// receiver does not stall. The output register decouples the two sides: the
// slave channel stays ready while the held result is being taken in the same
// cycle, and the input register holds one more byte while the receiver
// stalls. Reset returns the parser to plain text with light gray on black and
// empties both registers.
// ============================================================================
module ansi_color_escape_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] char_out, [11:8] fg_out, [15:12] bg_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_out_valid;
    logic [15:0]      r_out_data;
    acef_pkg::t_state r_state;
    acef_pkg::t_state n_state;
    logic             emit;
    logic             out_free;
    logic             process;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign process         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    acef_parser u_parser (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (n_state),
        .o_emit  (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= acef_pkg::STATE_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (process) begin
                r_state     <= n_state;
                r_out_valid <= emit;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
        end
        if (process && emit) begin
            r_out_data <= {r_state.bg, r_state.fg, r_in_char};
        end
    end

endmodule

// ===== rtl/acef_checker.sv =====
// ============================================================================
// acef_checker
// Port-level checks of the ANSI color escape filter, bound to the top level.
// ============================================================================
module acef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic in_fire;

    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled result changed or was dropped.");

    a_no_esc_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:0] != 8'h1B)
        else $error("An escape character reached the output.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_fire, 2))
        else $error("Result appeared without a transaction two cycles earlier.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled while the output register is empty.");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("Output valid right after reset.");

endmodule

bind ansi_color_escape_filter_unit acef_checker u_acef_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
